// ===== hdl/utf8_stream_decoder_macros.svh =====
// Assertion macros used by the checker file of the UTF-8 stream decoder.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8D_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define U8D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/utf8d_pkg.sv =====
// Types and constants of the UTF-8 stream decoder.
package utf8d_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;

    // Result queue depth, must be a power of two and at least 4.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    localparam logic [CP_W-1:0] REPL_CP   = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO   = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI   = 21'h00DFFF;

    // Input beat: one byte of text.
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              text_end;
    } t_in_beat;

    // Output beat: one decoded code point.
    typedef struct packed {
        logic [CP_W-1:0] scalar;
        logic            run_end;
    } t_out_beat;

    // Results produced by one input byte, zero to two of them.
    typedef struct packed {
        logic [1:0] count;
        t_out_beat  res0;
        t_out_beat  res1;
    } t_dec_res;

endpackage

// ===== hdl/utf8d_decode.sv =====
// Byte decoder: sequence state and per-byte result generation.
module utf8d_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  utf8d_pkg::t_in_beat i_beat,
    output utf8d_pkg::t_dec_res o_res
);

    logic [1:0]                 r_pend;
    logic [utf8d_pkg::CP_W-1:0] r_gath;
    logic [1:0]                 n_pend;
    logic [utf8d_pkg::CP_W-1:0] n_gath;

    logic [utf8d_pkg::BYTE_W-1:0] b;
    logic                         is_cont;
    logic [utf8d_pkg::CP_W-1:0]   cont_val;
    logic [utf8d_pkg::CP_W-1:0]   chk_val;
    utf8d_pkg::t_dec_res          res;

    assign b        = i_beat.data_byte;
    assign is_cont  = (b[7:6] == 2'b10);
    assign cont_val = {r_gath[14:0], b[5:0]};

    // Range check of a completed value
    always_comb begin
        if (cont_val > utf8d_pkg::CP_MAX ||
            (cont_val >= utf8d_pkg::SURR_LO && cont_val <= utf8d_pkg::SURR_HI)) begin
            chk_val = utf8d_pkg::REPL_CP;
        end else begin
            chk_val = cont_val;
        end
    end

    // Next state and result list, in emission order
    always_comb begin
        logic [1:0]                 cnt;
        logic [utf8d_pkg::CP_W-1:0] cp0;
        logic [utf8d_pkg::CP_W-1:0] cp1;
        logic                       fresh;
        cnt   = 2'd0;
        cp0   = '0;
        cp1   = '0;
        fresh = 1'b1;
        n_pend = r_pend;
        n_gath = r_gath;

        // Open sequence: continue it or flag it broken
        if (r_pend != 2'd0) begin
            if (is_cont) begin
                fresh  = 1'b0;
                n_pend = r_pend - 2'd1;
                if (n_pend == 2'd0) begin
                    cp0    = chk_val;
                    cnt    = 2'd1;
                    n_gath = '0;
                end else begin
                    n_gath = cont_val;
                end
            end else begin
                cp0    = utf8d_pkg::REPL_CP;
                cnt    = 2'd1;
                n_pend = 2'd0;
                n_gath = '0;
            end
        end

        // Byte decoded with no sequence open
        if (fresh) begin
            if (b[7] == 1'b0) begin
                if (cnt == 2'd0) cp0 = {13'd0, b};
                else             cp1 = {13'd0, b};
                cnt = cnt + 2'd1;
            end else if (b[7:5] == 3'b110) begin
                n_pend = 2'd1;
                n_gath = {16'd0, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
                n_pend = 2'd2;
                n_gath = {17'd0, b[3:0]};
            end else if (b[7:3] == 5'b11110) begin
                n_pend = 2'd3;
                n_gath = {18'd0, b[2:0]};
            end else begin
                if (cnt == 2'd0) cp0 = utf8d_pkg::REPL_CP;
                else             cp1 = utf8d_pkg::REPL_CP;
                cnt = cnt + 2'd1;
            end
        end

        // Text ends inside a sequence
        if (i_beat.text_end && n_pend != 2'd0) begin
            if (cnt == 2'd0) cp0 = utf8d_pkg::REPL_CP;
            else             cp1 = utf8d_pkg::REPL_CP;
            cnt    = cnt + 2'd1;
            n_pend = 2'd0;
            n_gath = '0;
        end

        res.count        = cnt;
        res.res0.scalar  = cp0;
        res.res0.run_end = (cnt == 2'd1);
        res.res1.scalar  = cp1;
        res.res1.run_end = 1'b1;
    end

    assign o_res = res;

    // Sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
            r_gath <= '0;
        end else if (i_accept) begin
            r_pend <= n_pend;
            r_gath <= n_gath;
        end
    end

endmodule

// ===== hdl/utf8d_out_queue.sv =====
// Result queue: takes up to two results per cycle, hands out one per beat.
module utf8d_out_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  utf8d_pkg::t_dec_res  i_res,
    output logic                 o_room,
    output logic                 o_valid,
    input  logic                 i_ready,
    output utf8d_pkg::t_out_beat o_beat
);

    utf8d_pkg::t_out_beat           r_mem [utf8d_pkg::QDEPTH];
    logic [utf8d_pkg::QPTR_W-1:0]   r_wr;
    logic [utf8d_pkg::QPTR_W-1:0]   r_rd;
    logic [utf8d_pkg::QCNT_W-1:0]   r_cnt;
    logic [utf8d_pkg::QPTR_W-1:0]   wr1;
    logic [utf8d_pkg::QCNT_W-1:0]   push_n;
    logic                           pop;

    assign wr1     = r_wr + 1'b1;
    assign push_n  = i_push ? {{(utf8d_pkg::QCNT_W-2){1'b0}}, i_res.count} : '0;
    assign pop     = (r_cnt != '0) && i_ready;
    assign o_valid = (r_cnt != '0);
    assign o_beat  = r_mem[r_rd];
    // Room for the worst case of two results
    assign o_room  = (r_cnt <= utf8d_pkg::QCNT_W'(utf8d_pkg::QDEPTH - 2));

    // Storage writes
    always_ff @(posedge i_clk) begin
        if (i_push && i_res.count != 2'd0) begin
            r_mem[r_wr] <= i_res.res0;
            if (i_res.count == 2'd2) begin
                r_mem[wr1] <= i_res.res1;
            end
        end
    end

    // Pointers and fill count; pointers wrap at the power-of-two depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + push_n[utf8d_pkg::QPTR_W-1:0];
            if (pop) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + push_n - {{(utf8d_pkg::QCNT_W-1){1'b0}}, pop};
        end
    end

endmodule

// ===== hdl/utf8_stream_decoder.sv =====
// Top level of the UTF-8 stream decoder.
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+-------------------------------
//  in      | i_valid | o_ready | i_beat  (data_byte, text_end)
//  out     | o_valid | i_ready | o_beat  (scalar, run_end)
//
// One byte per cycle is taken while the result queue has room for two results.
// A byte's results enter the queue at the edge it is accepted and reach the output
// behind any waiting results; it drains one result per cycle while i_ready is high,
// so bytes that give two results throttle the input through the four-entry queue.
// Reset clears the sequence state and empties the queue.
// An output stall holds the head result; input ready drops once three results wait.
module utf8_stream_decoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  utf8d_pkg::t_in_beat  i_beat,
    output logic                 o_valid,
    input  logic                 i_ready,
    output utf8d_pkg::t_out_beat o_beat
);

    logic                accept;
    utf8d_pkg::t_dec_res dec_res;

    assign accept = i_valid && o_ready;

    utf8d_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_beat   (i_beat),
        .o_res    (dec_res)
    );

    utf8d_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_res   (dec_res),
        .o_room  (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_beat  (o_beat)
    );

endmodule

// ===== hdl/utf8d_checker.sv =====
// Port-level checker for the UTF-8 stream decoder, bound to the top level.
`include "utf8_stream_decoder_macros.svh"

module utf8d_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_ready,
    input utf8d_pkg::t_in_beat  i_beat,
    input logic                 o_valid,
    input logic                 i_ready,
    input utf8d_pkg::t_out_beat o_beat
);

    // Stalled output beat holds
    `U8D_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_beat), "output beat changed while stalled")

    // Input backpressure only while results are waiting
    `U8D_ASSERT_NOW(a_ready_low, i_clk, i_rst_n, !o_ready, o_valid, "input stalled with empty queue")

    // A result appears only after an accepted byte
    `U8D_ASSERT_NOW(a_no_invent, i_clk, i_rst_n, $rose(o_valid), $past(i_valid && o_ready), "result without an accepted byte")

    // The last byte of a text always gives at least one result
    `U8D_ASSERT_NEXT(a_end_result, i_clk, i_rst_n, i_valid && o_ready && i_beat.text_end, o_valid, "text end gave no result")

endmodule

bind utf8_stream_decoder utf8d_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_beat  (i_beat),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_beat  (o_beat)
);
